[src/isq64_pkg.sv]
// ---------------------------------------------------------------------------
// isq64_pkg: shared types and constants for the 64-bit integer square root
// Widths of the radicand, root and partial remainder, and the item record
// that moves from cell to cell along the chain.
// ---------------------------------------------------------------------------
`default_nettype none

package isq64_pkg;

    localparam int RAD_W   = 64;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;  // remainder never exceeds 2*root
    localparam int STEPS   = ROOT_W;      // one root bit per cell

    typedef struct packed {
        logic [RAD_W-1:0]  rad;   // radicand bits not yet consumed, MSB first
        logic [REM_W-1:0]  rem;   // partial remainder
        logic [ROOT_W-1:0] root;  // root bits resolved so far
    } t_isq_data;

endpackage

`default_nettype wire

[src/isq64_cell.sv]
// ---------------------------------------------------------------------------
// isq64_cell: one digit step of the square root chain
// Brings in two radicand bits, tries root bit one against the remainder and
// registers the updated item. Per-cell valid with bubble collapsing ready.
// ---------------------------------------------------------------------------
`default_nettype none

module isq64_cell (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire isq64_pkg::t_isq_data i_data,
    output logic                  o_valid,
    input  wire                   i_ready,
    output isq64_pkg::t_isq_data  o_data
);
    import isq64_pkg::*;

    localparam int TRIAL_W = REM_W + 2;

    logic                 r_valid;
    t_isq_data            r_data;
    t_isq_data            n_data;
    logic [TRIAL_W-1:0]   w_cur;
    logic [TRIAL_W-1:0]   w_trial;
    logic [TRIAL_W:0]     w_diff;
    logic                 w_take;

    // trial divisor is 4*root + 1
    always_comb begin
        w_cur   = {i_data.rem, i_data.rad[RAD_W-1 -: 2]};
        w_trial = {{(TRIAL_W-ROOT_W-2){1'b0}}, i_data.root, 2'b01};
        w_diff  = {1'b0, w_cur} - {1'b0, w_trial};
        w_take  = ~w_diff[TRIAL_W];

        n_data.rad  = {i_data.rad[RAD_W-3:0], 2'b00};
        n_data.rem  = w_take ? w_diff[REM_W-1:0] : w_cur[REM_W-1:0];
        n_data.root = {i_data.root[ROOT_W-2:0], w_take};
    end

    assign o_ready = ~r_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

[src/integer_square_root_64_top.sv]
// ---------------------------------------------------------------------------
// integer_square_root_64_top: pipelined 64-bit integer square root
// Returns floor(sqrt(radicand)) as a 32-bit root, one item per cycle without stalls.
// ---------------------------------------------------------------------------
// The block takes one unsigned 64-bit radicand per cycle and returns the floor
// of its square root on o_root, exactly one result item per input item, in
// order. It is a chain of 32 identical cells; each cell resolves one root bit,
// MSB first, with the restoring digit-by-digit method (no multiplier: one
// 36-bit subtract and compare per cell). Throughput is one item per clock
// unless the output stalls; an item is registered in each cell in turn on
// its way to o_out_valid. Each cell has its own valid bit and ready is collapsed
// backwards, so empty slots are squeezed out while the output is stalled and
// o_in_ready only drops once every cell holds an item. No state survives an
// item; reset clears only the valid bits.
`default_nettype none

module integer_square_root_64_top (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [isq64_pkg::RAD_W-1:0]     i_radicand,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [isq64_pkg::ROOT_W-1:0]    o_root
);
    import isq64_pkg::*;

    // link k feeds cell k; link STEPS is the chain's output
    logic       w_valid [STEPS+1];
    logic       w_ready [STEPS+1];
    t_isq_data  w_data  [STEPS+1];
    logic [STEPS-1:0] w_full;

    assign w_valid[0]       = i_in_valid;
    assign o_in_ready       = w_ready[0];
    assign w_data[0].rad    = i_radicand;
    assign w_data[0].rem    = '0;
    assign w_data[0].root   = '0;

    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        isq64_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_data  (w_data[k+1])
        );
        assign w_full[k] = w_valid[k+1];
    end

    assign w_ready[STEPS] = i_out_ready;
    assign o_out_valid    = w_valid[STEPS];
    assign o_root         = w_data[STEPS].root;

    // ---- checks ----

    // finished remainder must not exceed twice the root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, w_data[STEPS].rem} <= {2'b00, o_root, 1'b0}))
        else $error("remainder out of range for finished root");

    // input only back-pressured when every cell is occupied
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&w_full))
        else $error("input stalled with a free cell in the chain");

    // items in flight change only by accepted input and output items
    a_item_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ($countones(w_full) == $past($countones(w_full))
                  + $past(int'(i_in_valid && o_in_ready))
                  - $past(int'(o_out_valid && i_out_ready))))
        else $error("item lost or duplicated in the chain");

endmodule

`default_nettype wire

[dv/integer_square_root_64_top_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// integer_square_root_64_top_tb: self-checking bench for the 64-bit root
// Drives radicands through the valid/ready input and checks every root that
// comes out, in order, against a bit-serial floor square root worked out
// here. A directed sweep of extremes and exact squares runs first, then
// random radicands with random gaps and stalls on both sides.
// ---------------------------------------------------------------------------

module integer_square_root_64_top_tb;

    import isq64_pkg::RAD_W;
    import isq64_pkg::ROOT_W;

    localparam int          CLK_PERIOD  = 20;
    localparam int          RESET_LEN   = 10;
    localparam int          RAND_ITEMS  = 730;
    localparam int          CALM_ITEMS  = 100;      // tail with no idling
    localparam int          DRAIN_WAIT  = 40;       // chain length plus margin
    localparam int          LONG_HOLD   = 120;      // well beyond 32 cells
    localparam int          HOLD_AFTER  = 150;      // roots seen before it
    localparam int          MAX_PRINTS  = 50;
    localparam longint      TIMEOUT_NS  = 4_000_000;
    localparam logic [ROOT_W-1:0] TRIAL_TOP = 32'h8000_0000;

    // one directed row: radicand, and the root where it is obvious
    typedef struct packed {
        logic [RAD_W-1:0]  radicand;
        logic              known;
        logic [ROOT_W-1:0] root;
    } t_sqrt_case;

    // one outstanding item: what went in and what must come out
    typedef struct packed {
        logic [RAD_W-1:0]  radicand;
        logic [ROOT_W-1:0] root;
    } t_sqrt_item;

    localparam int N_DIRECTED = 19;
    localparam t_sqrt_case DIRECTED_CASES [0:N_DIRECTED-1] = '{
        '{64'd0,                   1'b1, 32'd0},
        '{64'd1,                   1'b1, 32'd1},
        '{64'd2,                   1'b1, 32'd1},
        '{64'd3,                   1'b1, 32'd1},
        '{64'd4,                   1'b1, 32'd2},
        '{64'd8,                   1'b0, 32'd0},
        '{64'd15,                  1'b1, 32'd3},
        '{64'd16,                  1'b1, 32'd4},
        '{64'h0000_0000_FFFF_FFFF, 1'b1, 32'd65535},
        '{64'h0000_0001_0000_0000, 1'b1, 32'd65536},
        '{64'h3FFF_FFFF_FFFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        '{64'h4000_0000_0000_0000, 1'b1, 32'h8000_0000},
        '{64'h8000_0000_0000_0000, 1'b0, 32'd0},
        '{64'hFFFF_FFFE_0000_0000, 1'b1, 32'hFFFF_FFFE},
        '{64'hFFFF_FFFE_0000_0001, 1'b1, 32'hFFFF_FFFF},   // (2^32-1)^2
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 32'd0},
        '{64'h5555_5555_5555_5555, 1'b0, 32'd0},
        '{64'h0123_4567_89AB_CDEF, 1'b0, 32'd0}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [RAD_W-1:0]  i_radicand;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [ROOT_W-1:0] o_root;

    t_sqrt_item pending_roots [$];
    int         mismatch_count = 0;
    int         roots_seen     = 0;
    bit         calm_tail      = 1'b0;
    bit         long_hold_done = 1'b0;

    integer_square_root_64_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_radicand  (i_radicand),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_root      (o_root)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Floor square root by trial bits, MSB first: keep a bit when the
    // candidate squared still fits under the radicand. A 32-bit candidate
    // squared always fits in 64 bits, so the compare never overflows.
    function automatic logic [ROOT_W-1:0] floor_sqrt64(input logic [RAD_W-1:0] x);
        logic [ROOT_W-1:0] acc;
        logic [ROOT_W-1:0] probe;
        logic [ROOT_W-1:0] cand;
        logic [RAD_W-1:0]  square;
        acc   = '0;
        probe = TRIAL_TOP;
        while (probe != '0) begin
            cand   = acc | probe;
            square = {{(RAD_W-ROOT_W){1'b0}}, cand} * {{(RAD_W-ROOT_W){1'b0}}, cand};
            if (square <= x)
                acc = cand;
            probe = probe >> 1;
        end
        return acc;
    endfunction

    // Random radicand with a spread of shapes: full range, exact squares and
    // their neighbours, tiny values, random magnitudes, and values near the top.
    function automatic logic [RAD_W-1:0] random_radicand();
        logic [RAD_W-1:0]  full;
        logic [RAD_W-1:0]  k;
        logic [RAD_W-1:0]  r;
        full = {$urandom, $urandom};
        k    = {32'd0, $urandom};
        case ($urandom_range(0, 5))
            0, 5: r = full;
            1:    r = k * k + 64'($urandom_range(0, 2)) - 64'd1;
            2:    r = 64'($urandom_range(0, 1023));
            3:    r = full >> $urandom_range(0, 63);
            default: r = ~64'($urandom_range(0, 255));
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    // Offer one item and hold it until the block takes it. Gaps go in front
    // of the item so valid only ever drops between items.
    task automatic offer_radicand(input logic [RAD_W-1:0] rad, input logic known,
                                  input logic [ROOT_W-1:0] given_root);
        int gap;
        t_sqrt_item item;
        gap = 0;
        if (!calm_tail && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_radicand <= rad;
        do @(posedge i_clk); while (!o_in_ready);
        item.radicand = rad;
        item.root     = known ? given_root : floor_sqrt64(rad);
        pending_roots.push_back(item);
    endtask

    // Receiver: random stalls, one long hold-off so the chain fills and input
    // ready drops, and no stalls in the tail.
    initial begin
        int hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n) begin
                i_out_ready <= 1'b0;
            end else if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (!calm_tail && !long_hold_done && roots_seen >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                i_out_ready   <= 1'b0;
            end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
                hold_left    = $urandom_range(0, 3);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Result checker: roots come back in order, so each one is matched
    // against the oldest outstanding item.
    always @(posedge i_clk) begin
        t_sqrt_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            roots_seen++;
            if (pending_roots.size() == 0) begin
                report_mismatch($sformatf("root %0d with no item outstanding", o_root));
            end else begin
                want = pending_roots.pop_front();
                if (o_root !== want.root)
                    report_mismatch($sformatf("radicand %h: root %h, wanted %h",
                                              want.radicand, o_root, want.root));
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("integer_square_root_64_top regression: fail");
        $finish;
    end

    // Main sequence: reset, directed sweep, random items, drain, verdict.
    initial begin
        int n;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_radicand = '0;
        repeat (RESET_LEN) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, exact squares either side, odd bit patterns
        for (n = 0; n < N_DIRECTED; n++)
            offer_radicand(DIRECTED_CASES[n].radicand, DIRECTED_CASES[n].known,
                           DIRECTED_CASES[n].root);

        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n >= RAND_ITEMS - CALM_ITEMS)
                calm_tail = 1'b1;
            offer_radicand(random_radicand(), 1'b0, '0);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // wait out what is still in the chain, then a little longer for strays
        while (pending_roots.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0 && pending_roots.size() == 0)
            $display("integer_square_root_64_top regression: pass");
        else
            $display("integer_square_root_64_top regression: fail");
        $finish;
    end

endmodule
